// ----- src/imhq_pkg.sv -----
// Shared constants and types for the indexed max-heap queue.
`default_nettype none
package imhq_pkg;
	localparam int unsigned MAX_ELEMS_DEF = 64;
	localparam int unsigned ID_W = 6;
	localparam int unsigned PRIO_W = 32;
	localparam int unsigned COUNT_W = 7;

	typedef enum logic [1:0] {
		FUNC_INSERT   = 2'd0,
		FUNC_INCREASE = 2'd1,
		FUNC_REMOVE   = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;
endpackage
`default_nettype wire

// ----- src/imhq_mem.sv -----
// Single-port memory with registered read data, used for the heap tables.
`default_nettype none
module imhq_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 6
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- src/indexed_max_heap_queue.sv -----
// Top level of the indexed max-heap queue: sequencer, heap tables and priority compare.
//
//  channel  signals                              direction
//  in       in_valid/in_ready, func, id, priority_req   to block
//  out      out_valid/out_ready, ok, out_id, out_priority, count   from block
//
// Insert and increase walk up the heap level by level; remove walks down level by level;
// a rejected request goes to the result without touching the heap. The steps go through the
// single-port heap-slot, priority and slot-by-id memories, which have registered read data.
// After reset a clearing pass zeroes the tables; no item is taken meanwhile. One item is
// handled at a time; in_ready is low while it runs and while a result waits in the output
// register for out_ready.
`default_nettype none
module indexed_max_heap_queue
	import imhq_pkg::*;
#(
	parameter int unsigned MAX_ELEMS = MAX_ELEMS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic [ID_W-1:0]    id,
	input  wire logic signed [PRIO_W-1:0] priority_req,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    ok,
	output logic [ID_W-1:0]         out_id,
	output logic signed [PRIO_W-1:0] out_priority,
	output logic [COUNT_W-1:0]      count
);
	localparam int unsigned AW = $clog2(MAX_ELEMS);
	localparam int unsigned CW = $clog2(MAX_ELEMS + 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHK, S_CHK2,
		S_UP_RD, S_UP_P, S_UP_CMP,
		S_RM_RD, S_RM_TOP, S_RM_P, S_RM_LAST,
		S_DN_L, S_DN_LI, S_DN_LP, S_DN_R, S_DN_RI, S_DN_RP, S_DN_CMP,
		S_PLACE, S_DONE
	} state_t;

	state_t state_q;

	// Heap slot memory (position -> id), priority and slot-by-id memories.
	logic          hs_we, pr_we, sl_we;
	logic [AW-1:0] hs_addr, pr_addr, sl_addr;
	logic [AW-1:0] hs_wd, sl_wd, hs_rd, sl_rd;
	logic [PRIO_W-1:0] pr_wd, pr_rd;
	logic [MAX_ELEMS-1:0] present_q;

	imhq_mem #(.DEPTH(MAX_ELEMS), .WIDTH(AW)) u_heap (
		.clk(clk), .we(hs_we), .addr(hs_addr), .wdata(hs_wd), .rdata(hs_rd));
	imhq_mem #(.DEPTH(MAX_ELEMS), .WIDTH(PRIO_W)) u_prio (
		.clk(clk), .we(pr_we), .addr(pr_addr), .wdata(pr_wd), .rdata(pr_rd));
	imhq_mem #(.DEPTH(MAX_ELEMS), .WIDTH(AW)) u_slot (
		.clk(clk), .we(sl_we), .addr(sl_addr), .wdata(sl_wd), .rdata(sl_rd));

	logic [1:0]        func_q;
	logic [ID_W-1:0]   idin_q;
	logic [AW-1:0]     ident_q, pid_q, cid_q;
	logic signed [PRIO_W-1:0] preq_q, mprio_q, cprio_q;
	logic [AW-1:0]     pos_q, par_q, cpos_q;
	logic [CW-1:0]     held_q;
	logic              ok_q;
	logic [ID_W-1:0]   oid_q;
	logic signed [PRIO_W-1:0] opr_q;
	logic              cmp_gt;
	logic signed [PRIO_W-1:0] cmp_a, cmp_b;

	// Shared compare unit: a > b.
	assign cmp_gt = cmp_a > cmp_b;

	logic [AW:0]  lchild, rchild;
	logic [AW-1:0] up_par;
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + (AW+1)'(1);
	assign up_par = (pos_q - AW'(1)) >> 1;

	always_comb begin
		hs_we = 1'b0; pr_we = 1'b0; sl_we = 1'b0;
		hs_addr = pos_q; pr_addr = ident_q; sl_addr = ident_q;
		hs_wd = ident_q; pr_wd = preq_q; sl_wd = pos_q;
		cmp_a = preq_q; cmp_b = pr_rd;
		case (state_q)
			S_CLEAR: begin
				hs_we = 1'b1; pr_we = 1'b1; sl_we = 1'b1;
				hs_addr = pos_q; pr_addr = pos_q; sl_addr = pos_q;
				hs_wd = '0; pr_wd = '0; sl_wd = '0;
			end
			S_CHK: begin
				pr_addr = idin_q[AW-1:0];
				sl_addr = idin_q[AW-1:0];
			end
			S_UP_RD: begin
				hs_addr = up_par;
			end
			S_UP_P: begin
				pr_addr = hs_rd;
			end
			S_UP_CMP: begin
				cmp_a = mprio_q; cmp_b = pr_rd;
				if (pos_q != '0 && cmp_gt) begin
					hs_we = 1'b1; hs_addr = pos_q; hs_wd = pid_q;
					sl_we = 1'b1; sl_addr = pid_q; sl_wd = pos_q;
				end
			end
			S_RM_RD: hs_addr = '0;
			S_RM_TOP: pr_addr = hs_rd;
			S_RM_P: hs_addr = held_q[AW-1:0];
			S_RM_LAST: pr_addr = hs_rd;
			S_DN_L: hs_addr = lchild[AW-1:0];
			S_DN_LI: pr_addr = hs_rd;
			S_DN_R: hs_addr = rchild[AW-1:0];
			S_DN_RI: pr_addr = hs_rd;
			S_DN_CMP: begin
				cmp_a = cprio_q; cmp_b = mprio_q;
				if (cmp_gt) begin
					hs_we = 1'b1; hs_addr = pos_q; hs_wd = cid_q;
					sl_we = 1'b1; sl_addr = cid_q; sl_wd = pos_q;
				end
			end
			S_DN_RP: begin
				cmp_a = pr_rd; cmp_b = cprio_q;
			end
			S_PLACE: begin
				hs_we = 1'b1; hs_addr = pos_q; hs_wd = ident_q;
				sl_we = 1'b1; sl_addr = ident_q; sl_wd = pos_q;
				pr_we = (func_q != FUNC_REMOVE); pr_addr = ident_q; pr_wd = preq_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign ok = ok_q;
	assign out_id = oid_q;
	assign out_priority = opr_q;
	assign count = COUNT_W'(held_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pos_q <= '0;
			held_q <= '0;
			present_q <= '0;
			ok_q <= 1'b0;
			oid_q <= '0;
			opr_q <= '0;
			func_q <= '0;
			idin_q <= '0;
			preq_q <= '0;
			ident_q <= '0;
			pid_q <= '0;
			cid_q <= '0;
			mprio_q <= '0;
			cprio_q <= '0;
			par_q <= '0;
			cpos_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					pos_q <= pos_q + AW'(1);
					if (pos_q == AW'(MAX_ELEMS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						idin_q <= id;
						preq_q <= priority_req;
						ok_q <= 1'b0; oid_q <= '0; opr_q <= '0;
						state_q <= (func_t'(func) == FUNC_REMOVE) ? S_RM_RD : S_CHK;
					end
				end
				S_CHK: state_q <= S_CHK2;
				S_CHK2: begin
					ident_q <= idin_q[AW-1:0];
					mprio_q <= preq_q;
					state_q <= S_DONE;
					if (32'(idin_q) < MAX_ELEMS) begin
						if (func_t'(func_q) == FUNC_INSERT) begin
							if (!present_q[idin_q[AW-1:0]] && 32'(held_q) < MAX_ELEMS) begin
								present_q[idin_q[AW-1:0]] <= 1'b1;
								pos_q <= held_q[AW-1:0];
								held_q <= held_q + CW'(1);
								ok_q <= 1'b1;
								state_q <= S_UP_RD;
							end
						end else if (func_t'(func_q) == FUNC_INCREASE) begin
							if (present_q[idin_q[AW-1:0]] && cmp_gt) begin
								pos_q <= sl_rd;
								ok_q <= 1'b1;
								state_q <= S_UP_RD;
							end
						end
					end
				end
				S_UP_RD: begin
					par_q <= up_par;
					if (pos_q == '0) state_q <= S_PLACE;
					else state_q <= S_UP_P;
				end
				S_UP_P: begin
					pid_q <= hs_rd;
					state_q <= S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_gt) begin
						pos_q <= par_q;
						par_q <= (par_q - AW'(1)) >> 1;
						state_q <= (par_q == '0) ? S_PLACE : S_UP_RD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_RM_RD: begin
					if (held_q == '0) state_q <= S_DONE;
					else state_q <= S_RM_TOP;
				end
				S_RM_TOP: begin
					oid_q <= ID_W'(hs_rd);
					present_q[hs_rd] <= 1'b0;
					held_q <= held_q - CW'(1);
					state_q <= S_RM_P;
				end
				S_RM_P: begin
					opr_q <= pr_rd;
					ok_q <= 1'b1;
					pos_q <= '0;
					state_q <= (held_q == '0) ? S_DONE : S_RM_LAST;
				end
				S_RM_LAST: begin
					ident_q <= hs_rd;
					state_q <= S_DN_L;
				end
				S_DN_L: begin
					if (CW'(lchild) >= held_q || lchild > (AW+1)'(MAX_ELEMS - 1)) begin
						state_q <= S_PLACE;
					end else begin
						mprio_q <= pr_rd;
						state_q <= S_DN_LI;
					end
				end
				S_DN_LI: begin
					cid_q <= hs_rd;
					cpos_q <= lchild[AW-1:0];
					state_q <= S_DN_LP;
				end
				S_DN_LP: begin
					cprio_q <= pr_rd;
					state_q <= (CW'(rchild) < held_q && rchild <= (AW+1)'(MAX_ELEMS - 1))
						? S_DN_R : S_DN_CMP;
				end
				S_DN_R: state_q <= S_DN_RI;
				S_DN_RI: begin
					pid_q <= hs_rd;
					state_q <= S_DN_RP;
				end
				S_DN_RP: begin
					if (cmp_gt) begin
						cprio_q <= pr_rd;
						cid_q <= pid_q;
						cpos_q <= rchild[AW-1:0];
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (cmp_gt) begin
						pos_q <= cpos_q;
						state_q <= S_DN_L;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- test/indexed_max_heap_queue_tb.sv -----
// Testbench for the indexed max-heap queue: random and directed operations checked against a heap predictor.
`timescale 1ns / 100ps
`default_nettype none
module indexed_max_heap_queue_tb;
	import imhq_pkg::*;

	localparam int unsigned NELEM = 64;
	localparam int unsigned STALL_LIMIT = 20000;

	typedef struct packed {
		logic ok;
		logic [ID_W-1:0] rid;
		logic signed [PRIO_W-1:0] prio;
		logic [COUNT_W-1:0] cnt;
	} heap_result_t;

	class heap_scoreboard;
		logic [ID_W-1:0] slots[NELEM];
		logic signed [PRIO_W-1:0] prio_of[NELEM];
		int unsigned slot_of[NELEM];
		bit present[NELEM];
		int unsigned held;
		heap_result_t pending[$];
		int errors;

		function void clear();
			for (int i = 0; i < NELEM; i++) begin
				slots[i] = '0;
				prio_of[i] = '0;
				slot_of[i] = 0;
				present[i] = 0;
			end
			held = 0;
			errors = 0;
		endfunction

		function void put(int unsigned pos, logic [ID_W-1:0] ident);
			slots[pos] = ident;
			slot_of[ident] = pos;
		endfunction

		function void rise(int unsigned pos);
			logic [ID_W-1:0] ident;
			int unsigned par;
			ident = slots[pos];
			while (pos > 0) begin
				par = (pos - 1) / 2;
				if (!(prio_of[slots[par]] < prio_of[ident]))
					break;
				put(pos, slots[par]);
				pos = par;
			end
			put(pos, ident);
		endfunction

		function void sink(int unsigned pos);
			logic [ID_W-1:0] ident;
			int unsigned l, c;
			ident = slots[pos];
			forever begin
				l = 2 * pos + 1;
				if (l >= held)
					break;
				c = l;
				if (l + 1 < held && prio_of[slots[l + 1]] > prio_of[slots[l]])
					c = l + 1;
				if (!(prio_of[slots[c]] > prio_of[ident]))
					break;
				put(pos, slots[c]);
				pos = c;
			end
			put(pos, ident);
		endfunction

		function void note_request(logic [1:0] op, logic [ID_W-1:0] ident,
				logic signed [PRIO_W-1:0] pr);
			heap_result_t r;
			r = '0;
			case (func_t'(op))
				FUNC_INSERT: begin
					if (!present[ident] && held < NELEM) begin
						present[ident] = 1;
						prio_of[ident] = pr;
						put(held, ident);
						held++;
						rise(held - 1);
						r.ok = 1;
					end
				end
				FUNC_INCREASE: begin
					if (present[ident] && prio_of[ident] < pr) begin
						prio_of[ident] = pr;
						rise(slot_of[ident]);
						r.ok = 1;
					end
				end
				FUNC_REMOVE: begin
					if (held > 0) begin
						r.rid = slots[0];
						r.prio = prio_of[slots[0]];
						present[slots[0]] = 0;
						held--;
						if (held > 0) begin
							put(0, slots[held]);
							sink(0);
						end
						r.ok = 1;
					end
				end
				default: ;
			endcase
			r.cnt = held[COUNT_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(heap_result_t got);
			heap_result_t want;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d, actual %0d", want.ok, got.ok);
				errors++;
			end
			if (got.rid !== want.rid) begin
				$error("out_id: expected %0d, actual %0d", want.rid, got.rid);
				errors++;
			end
			if (got.prio !== want.prio) begin
				$error("out_priority: expected %0d, actual %0d", want.prio, got.prio);
				errors++;
			end
			if (got.cnt !== want.cnt) begin
				$error("count: expected %0d, actual %0d", want.cnt, got.cnt);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] func = '0;
	logic [ID_W-1:0] id = '0;
	logic signed [PRIO_W-1:0] priority_req = '0;
	logic out_valid;
	logic out_ready = 0;
	logic ok;
	logic [ID_W-1:0] out_id;
	logic signed [PRIO_W-1:0] out_priority;
	logic [COUNT_W-1:0] count;

	heap_scoreboard sb;
	bit idle_on = 1;
	int unsigned quiet_cycles = 0;

	indexed_max_heap_queue u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .id(id), .priority_req(priority_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.ok(ok), .out_id(out_id), .out_priority(out_priority), .count(count)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(func, id, priority_req);
			if (out_valid && out_ready)
				sb.check_result('{ok, out_id, out_priority, count});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	always begin
		@(negedge clk);
		if (!arst_n) begin
			out_ready <= 0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ready <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			out_ready <= 1;
		end else begin
			out_ready <= 1;
		end
	end

	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task automatic send_op(func_t op, logic [ID_W-1:0] ident, logic signed [PRIO_W-1:0] pr);
		in_valid <= 1;
		func <= op;
		id <= ident;
		priority_req <= pr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		idle_gap();
	endtask

	task automatic send_raw(logic [1:0] op, logic [ID_W-1:0] ident,
			logic signed [PRIO_W-1:0] pr);
		send_op(func_t'(op), ident, pr);
	endtask

	function automatic logic signed [PRIO_W-1:0] rand_prio();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(PRIO_W'($urandom_range(0, 15)));
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	initial begin
		logic [1:0] op;
		int unsigned pick;
		sb = new();
		sb.clear();
		repeat (2) @(negedge clk);
		arst_n = 1;

		send_op(FUNC_REMOVE, 6'd0, 32'sd0);
		send_raw(FUNC_NONE, 6'd63, 32'sh7fffffff);
		send_op(FUNC_INCREASE, 6'd5, 32'sd1);
		send_op(FUNC_INSERT, 6'd0, 32'sh80000000);
		send_op(FUNC_INSERT, 6'd63, 32'sh7fffffff);
		send_op(FUNC_INSERT, 6'd63, 32'sd3);
		send_op(FUNC_INSERT, 6'd21, 32'sd0);
		send_op(FUNC_INSERT, 6'd42, 32'sd0);
		send_op(FUNC_INCREASE, 6'd21, 32'sd0);
		send_op(FUNC_INCREASE, 6'd21, -32'sd1);
		send_op(FUNC_INCREASE, 6'd0, 32'sh7fffffff);
		send_op(FUNC_INCREASE, 6'd42, 32'sd7);
		send_raw(FUNC_NONE, 6'd0, 32'sd0);
		repeat (6) send_op(FUNC_REMOVE, 6'd63, 32'sh7fffffff);
		for (int i = 0; i < NELEM; i++)
			send_op(FUNC_INSERT, i[ID_W-1:0], rand_prio());
		send_op(FUNC_INSERT, 6'd9, 32'sd1);
		wait_drained();

		for (int n = 0; n < 1750; n++) begin
			if (n == 1500)
				idle_on = 0;
			if (n == 800)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 2)
				op = FUNC_NONE;
			else if (sb.held < 8)
				op = pick < 65 ? FUNC_INSERT : (pick < 85 ? FUNC_INCREASE : FUNC_REMOVE);
			else if (sb.held > 56)
				op = pick < 25 ? FUNC_INSERT : (pick < 50 ? FUNC_INCREASE : FUNC_REMOVE);
			else
				op = pick < 40 ? FUNC_INSERT : (pick < 70 ? FUNC_INCREASE : FUNC_REMOVE);
			send_raw(op, ID_W'($urandom_range(0, NELEM - 1)), rand_prio());
		end

		in_valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
src/imhq_pkg.sv
src/imhq_mem.sv
src/indexed_max_heap_queue.sv
test/indexed_max_heap_queue_tb.sv
